>>> sv/sha256_pkg.sv
// sha256_pkg: shared types and constants of the SHA-256 stream hasher
// holds the initial hash values, the round constants and the schedule tap bundle
// no dependencies
package sha256_pkg;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
  } sched_taps_t;

  localparam int unsigned COUNT_W = 61;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam hash_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> sv/sha256_round.sv
// sha256_round: one SHA-256 compression round and one message schedule word
// shared unit stepped once per cycle by the sequencer in sha256_stream_hasher
// depends on sha256_pkg
module sha256_round (
  input  sha256_pkg::hash_t       state_i,
  input  sha256_pkg::sched_taps_t taps_i,
  input  logic [31:0]             k_i,
  output sha256_pkg::hash_t       state_o,
  output logic [31:0]             sched_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, small_s0, small_s1;

  always_comb begin
    big_s1 = rotr(state_i[4], 6) ^ rotr(state_i[4], 11) ^ rotr(state_i[4], 25);
    big_s0 = rotr(state_i[0], 2) ^ rotr(state_i[0], 13) ^ rotr(state_i[0], 22);
    ch = (state_i[4] & state_i[5]) ^ (~state_i[4] & state_i[6]);
    maj = (state_i[0] & state_i[1]) ^ (state_i[0] & state_i[2]) ^ (state_i[1] & state_i[2]);
    t1 = state_i[7] + big_s1 + ch + k_i + taps_i.w0;
    t2 = big_s0 + maj;
    state_o[7] = state_i[6];
    state_o[6] = state_i[5];
    state_o[5] = state_i[4];
    state_o[4] = state_i[3] + t1;
    state_o[3] = state_i[2];
    state_o[2] = state_i[1];
    state_o[1] = state_i[0];
    state_o[0] = t1 + t2;
  end

  always_comb begin
    small_s1 = rotr(taps_i.w14, 17) ^ rotr(taps_i.w14, 19) ^ (taps_i.w14 >> 10);
    small_s0 = rotr(taps_i.w1, 7) ^ rotr(taps_i.w1, 18) ^ (taps_i.w1 >> 3);
    sched_o = small_s1 + taps_i.w9 + small_s0 + taps_i.w0;
  end

endmodule

>>> sv/sha256_stream_hasher.sv
// SHA-256 over a byte stream. A request carrying a byte (tuser high) is written into the block buffer; the
// request that completes a 64-byte block is followed by the busy states S_COMP (64 rounds of the
// shared round unit) and S_ADD (the hash add), during which s_axis_tready is low. A request
// with tlast pads the message one byte per cycle into the block buffer and compresses one or
// two more blocks, then the eight digest words leave on the master side, word 0 first, tlast on
// word 7. Input is taken again while the digest drains.
// depends on sha256_pkg and sha256_round
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] round_q, round_d;
  logic [5:0] pos_q, pos_d;
  logic end_q, end_d, pad_q, pad_d, first_q, first_d, two_q, two_d;
  logic [sha256_pkg::COUNT_W-1:0] count_q, count_d;
  sha256_pkg::hash_t hash_q, hash_d, v_q, v_d, dig_q, dig_d, round_state;
  logic obusy_q, obusy_d;
  logic [2:0] oidx_q, oidx_d;
  logic [31:0] w_q [16];
  logic [31:0] sched_new;
  sha256_pkg::sched_taps_t taps;
  logic in_acc, out_acc, wr_en, shift_en;
  logic [5:0] wr_pos;
  logic [7:0] wr_byte, len_byte;
  logic [63:0] bit_len;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = obusy_q;
  assign m_axis_tdata = dig_q[0];
  assign m_axis_tuser = oidx_q;
  assign m_axis_tlast = (oidx_q == 3'd7);

  assign bit_len = {count_q, 3'b000};
  assign len_byte = bit_len[{~pos_q[2:0], 3'b000} +: 8];

  assign taps.w0 = w_q[0];
  assign taps.w1 = w_q[1];
  assign taps.w9 = w_q[9];
  assign taps.w14 = w_q[14];

  sha256_round u_round (
    .state_i (v_q),
    .taps_i  (taps),
    .k_i     (sha256_pkg::ROUND_K[round_q]),
    .state_o (round_state),
    .sched_o (sched_new)
  );

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    pos_d = pos_q;
    end_d = end_q;
    pad_d = pad_q;
    first_d = first_q;
    two_d = two_q;
    count_d = count_q;
    hash_d = hash_q;
    v_d = v_q;
    dig_d = dig_q;
    obusy_d = obusy_q;
    oidx_d = oidx_q;
    wr_en = 1'b0;
    wr_pos = count_q[5:0];
    wr_byte = s_axis_tdata;
    shift_en = 1'b0;

    if (out_acc) begin
      dig_d = dig_q >> 32;
      oidx_d = oidx_q + 3'd1;
      if (oidx_q == 3'd7) begin
        obusy_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            wr_en = 1'b1;
            count_d = count_q + sha256_pkg::COUNT_W'(1);
          end
          end_d = s_axis_tlast;
          if (s_axis_tuser && (count_q[5:0] == sha256_pkg::LAST_POS)) begin
            state_d = S_COMP;
            v_d = hash_q;
            round_d = 6'd0;
          end else if (s_axis_tlast) begin
            state_d = S_PAD;
            pos_d = count_d[5:0];
            pad_d = 1'b1;
            first_d = 1'b1;
            two_d = (count_d[5:0] >= sha256_pkg::LEN_POS);
          end
        end
      end
      S_COMP: begin
        v_d = round_state;
        shift_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == sha256_pkg::LAST_ROUND) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        if (!end_q) begin
          state_d = S_IDLE;
        end else if (!pad_q) begin
          state_d = S_PAD;
          pos_d = 6'd0;
          pad_d = 1'b1;
          first_d = 1'b1;
          two_d = 1'b0;
        end else if (two_q) begin
          state_d = S_PAD;
          pos_d = 6'd0;
          first_d = 1'b0;
          two_d = 1'b0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_PAD: begin
        wr_en = 1'b1;
        wr_pos = pos_q;
        if (first_q) begin
          wr_byte = sha256_pkg::PAD_BYTE;
        end else if (!two_q && (pos_q >= sha256_pkg::LEN_POS)) begin
          wr_byte = len_byte;
        end else begin
          wr_byte = 8'h00;
        end
        first_d = 1'b0;
        if (pos_q == sha256_pkg::LAST_POS) begin
          state_d = S_COMP;
          v_d = hash_q;
          round_d = 6'd0;
        end else begin
          pos_d = pos_q + 6'd1;
        end
      end
      S_OUT: begin
        if (!obusy_q) begin
          dig_d = hash_q;
          obusy_d = 1'b1;
          oidx_d = 3'd0;
          hash_d = sha256_pkg::HASH_IV;
          count_d = '0;
          end_d = 1'b0;
          pad_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= 6'd0;
      pos_q <= 6'd0;
      end_q <= 1'b0;
      pad_q <= 1'b0;
      first_q <= 1'b0;
      two_q <= 1'b0;
      count_q <= '0;
      hash_q <= sha256_pkg::HASH_IV;
      obusy_q <= 1'b0;
      oidx_q <= 3'd0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      pos_q <= pos_d;
      end_q <= end_d;
      pad_q <= pad_d;
      first_q <= first_d;
      two_q <= two_d;
      count_q <= count_d;
      hash_q <= hash_d;
      obusy_q <= obusy_d;
      oidx_q <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    dig_q <= dig_d;
  end

  // block buffer doubles as the 16-word schedule window
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= sched_new;
    end else if (wr_en) begin
      w_q[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COMP) |-> (round_q == 6'd0))
    else $error("round counter not parked outside compression");

  a_comp_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && round_q == sha256_pkg::LAST_ROUND) |=> (state_q == S_ADD))
    else $error("compression did not end after the last round");

  a_two_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    two_q |-> (end_q && pad_q))
    else $error("second padding block pending outside a closing message");

  a_digest_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !obusy_q) |=> (obusy_q && oidx_q == 3'd0 && count_q == '0))
    else $error("digest hand-off did not start at word zero");

endmodule
